### hdl/e2c_pkg.sv
// shared types, constants and functions for the equirectangular to cubemap address generator
`default_nettype none
package e2c_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int WORK_SHIFT      = 8;
  localparam int VEC_W           = 26;  // signed direction component, q2.16 scaled by 2^8
  localparam int ROOT_W          = 25;  // magnitude of the x-z radius
  localparam int SQ_W            = 51;  // sum of two squares plus headroom
  localparam int CORDIC_W        = 28;  // cordic working width
  localparam int ATAN_STEPS      = 24;
  localparam int MAX_FACE_LOG2_D = 10;
  localparam int ANGLE_BITS_D    = 18;

  localparam logic [15:0] SOURCE_WIDTH_RESET  = 16'd2048;
  localparam logic [15:0] SOURCE_HEIGHT_RESET = 16'd1024;

  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_code_t;

  typedef struct packed {
    logic [2:0] face;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [15:0] sample_x;
    logic [15:0] sample_y;
    logic [31:0] source_index;
    logic        bad_request;
  } out_word_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // rounded half up to ab bits of a turn
  function automatic logic [31:0] atan_step(input int i, input int ab);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ab));
    return 32'(sum >> (32 - ab));
  endfunction

endpackage
`default_nettype wire

### hdl/e2c_sqrt.sv
// pipelined floor square root of x^2 + z^2, one root bit per stage
`default_nettype none
module e2c_sqrt
  import e2c_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    valid_in,
  input  wire logic signed [VEC_W-1:0] vx,
  input  wire logic signed [VEC_W-1:0] vz,
  input  wire logic [SIDE_W-1:0]       side_in,
  output logic                         valid_out,
  output logic [ROOT_W-1:0]            root,
  output logic [SIDE_W-1:0]            side_out
);

  logic [ROOT_W-1:0]     mag_x, mag_z;
  logic [2*ROOT_W-1:0]   sq_x, sq_z;
  logic                  sq_valid;
  logic [SIDE_W-1:0]     sq_side;

  logic                  st_valid [0:ROOT_W];
  logic [SQ_W-1:0]       st_rem   [0:ROOT_W];
  logic [ROOT_W-1:0]     st_q     [0:ROOT_W];
  logic [SIDE_W-1:0]     st_side  [0:ROOT_W];

  assign mag_x = ROOT_W'(vx < 0 ? -vx : vx);
  assign mag_z = ROOT_W'(vz < 0 ? -vz : vz);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid    <= 1'b0;
      st_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid    <= valid_in;
      st_valid[0] <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x       <= mag_x * mag_x;
      sq_z       <= mag_z * mag_z;
      sq_side    <= side_in;
      st_rem[0]  <= SQ_W'(sq_x) + SQ_W'(sq_z);
      st_q[0]    <= '0;
      st_side[0] <= sq_side;
    end
  end

  for (genvar t = 0; t < ROOT_W; t++) begin : g_bit
    localparam int J = ROOT_W - 1 - t;
    logic [SQ_W-1:0] cand;
    assign cand = (SQ_W'(st_q[t]) << (J + 1)) + (SQ_W'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[t+1] <= 1'b0;
      end else if (en) begin
        st_valid[t+1] <= st_valid[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_side[t+1] <= st_side[t];
        if (st_rem[t] >= cand) begin
          st_rem[t+1] <= st_rem[t] - cand;
          st_q[t+1]   <= st_q[t] | (ROOT_W'(1) << J);
        end else begin
          st_rem[t+1] <= st_rem[t];
          st_q[t+1]   <= st_q[t];
        end
      end
    end
  end

  assign valid_out = st_valid[ROOT_W];
  assign root      = st_q[ROOT_W];
  assign side_out  = st_side[ROOT_W];

endmodule
`default_nettype wire

### hdl/e2c_cordic.sv
// pipelined cordic vectoring unit giving atan2 as a turn fraction
`default_nettype none
module e2c_cordic
  import e2c_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_D,
  parameter int SIDE_W     = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      valid_in,
  input  wire logic signed [VEC_W-1:0]   px_in,
  input  wire logic signed [VEC_W-1:0]   py_in,
  input  wire logic [SIDE_W-1:0]         side_in,
  output logic                           valid_out,
  output logic signed [ANGLE_BITS+1:0]   angle,
  output logic [SIDE_W-1:0]              side_out
);

  localparam int AW = ANGLE_BITS + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (ANGLE_BITS - 1);

  logic                       st_valid [0:ANGLE_BITS];
  logic                       st_zero  [0:ANGLE_BITS];
  logic signed [CORDIC_W-1:0] st_x     [0:ANGLE_BITS];
  logic signed [CORDIC_W-1:0] st_y     [0:ANGLE_BITS];
  logic signed [AW-1:0]       st_ang   [0:ANGLE_BITS];
  logic [SIDE_W-1:0]          st_side  [0:ANGLE_BITS];

  logic signed [CORDIC_W-1:0] ext_x, ext_y;

  assign ext_x = CORDIC_W'(px_in);
  assign ext_y = CORDIC_W'(py_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= valid_in;
    end
  end

  // left half plane is turned by half a turn first
  always_ff @(posedge clk) begin
    if (en) begin
      st_side[0] <= side_in;
      st_zero[0] <= (px_in == 0) && (py_in == 0);
      if (px_in < 0) begin
        st_x[0]   <= -ext_x;
        st_y[0]   <= -ext_y;
        st_ang[0] <= (py_in >= 0) ? HALF : -HALF;
      end else begin
        st_x[0]   <= ext_x;
        st_y[0]   <= ext_y;
        st_ang[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_iter
    localparam logic signed [AW-1:0] STEP = AW'(atan_step(i, ANGLE_BITS));

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i+1] <= 1'b0;
      end else if (en) begin
        st_valid[i+1] <= st_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_side[i+1] <= st_side[i];
        st_zero[i+1] <= st_zero[i];
        if (st_y[i] > 0) begin
          st_x[i+1]   <= st_x[i] + (st_y[i] >>> i);
          st_y[i+1]   <= st_y[i] - (st_x[i] >>> i);
          st_ang[i+1] <= st_ang[i] + STEP;
        end else begin
          st_x[i+1]   <= st_x[i] - (st_y[i] >>> i);
          st_y[i+1]   <= st_y[i] + (st_x[i] >>> i);
          st_ang[i+1] <= st_ang[i] - STEP;
        end
      end
    end
  end

  assign valid_out = st_valid[ANGLE_BITS];
  assign angle     = st_zero[ANGLE_BITS] ? '0 : st_ang[ANGLE_BITS];
  assign side_out  = st_side[ANGLE_BITS];

endmodule
`default_nettype wire

### hdl/equirect_to_cubemap_address.sv
// top level of the equirectangular to cubemap address generator
`default_nettype none
// Takes one cube-face pixel word per cycle and returns one source address word per
// cycle; it passes through the input register, the direction stage, 27
// square-root stages, ANGLE_BITS + 1 cordic stages run side by side for both angles,
// then four scaling and indexing stages and the output register. The whole pipeline
// holds while the output register is full and stalled, so in_stall follows out_stall
// when the output is occupied. The face size follows source_height; write the two
// size registers only while no pixel is in flight.
module equirect_to_cubemap_address
  import e2c_pkg::*;
#(
  parameter int MAX_FACE_LOG2 = MAX_FACE_LOG2_D,
  parameter int ANGLE_BITS    = ANGLE_BITS_D
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = ANGLE_BITS + 2;
  localparam int UW = ANGLE_BITS + 1;
  localparam int PW = UW + 16;
  localparam logic signed [AW:0] HALF = (AW+1)'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AW:0] FULL = (AW+1)'(1) <<< ANGLE_BITS;
  localparam logic signed [VEC_W-1:0] ONE = VEC_W'(1) <<< (FRAC_BITS + WORK_SHIFT);
  localparam int SIDE_SQ = 1 + 3 * VEC_W;

  logic [15:0] source_width, source_height;
  logic        adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RESET;
      source_height <= SOURCE_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic     v1;
  in_word_t w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= in_data;
    end
  end

  // face size and direction
  logic [3:0]              lg_h, k;
  logic                    bad1;
  logic [27:0]             a_sh, b_sh;
  logic signed [VEC_W-1:0] a_w, b_w, dx, dy, dz;

  always_comb begin
    lg_h = '0;
    for (int i = 1; i < 16; i++) begin
      if (source_height[i]) begin
        lg_h = 4'(i);
      end
    end
  end

  assign k    = (lg_h > 4'(MAX_FACE_LOG2)) ? 4'(MAX_FACE_LOG2) : lg_h;
  assign bad1 = (w1.face > FACE_NEG_Z) || ((w1.pixel_x >> k) != '0) ||
                ((w1.pixel_y >> k) != '0);
  assign a_sh = {17'd0, w1.pixel_x, 1'b1} << (5'(FRAC_BITS) - 5'(k));
  assign b_sh = {17'd0, w1.pixel_y, 1'b1} << (5'(FRAC_BITS) - 5'(k));
  assign a_w  = (VEC_W'(a_sh[17:0]) - (VEC_W'(1) <<< FRAC_BITS)) <<< WORK_SHIFT;
  assign b_w  = (VEC_W'(b_sh[17:0]) - (VEC_W'(1) <<< FRAC_BITS)) <<< WORK_SHIFT;

  always_comb begin
    case (face_code_t'(w1.face))
      FACE_POS_X: begin dx = ONE;  dy = -b_w; dz = -a_w; end
      FACE_NEG_X: begin dx = -ONE; dy = -b_w; dz = a_w;  end
      FACE_POS_Y: begin dx = a_w;  dy = ONE;  dz = b_w;  end
      FACE_NEG_Y: begin dx = a_w;  dy = -ONE; dz = -b_w; end
      FACE_POS_Z: begin dx = a_w;  dy = -b_w; dz = ONE;  end
      default:    begin dx = -a_w; dy = -b_w; dz = -ONE; end
    endcase
  end

  // stage 2
  logic                    v2, bad2;
  logic signed [VEC_W-1:0] x2, y2, z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad2 <= bad1;
      x2   <= dx;
      y2   <= dy;
      z2   <= dz;
    end
  end

  logic                    sq_valid;
  logic [ROOT_W-1:0]       root;
  logic [SIDE_SQ-1:0]      sq_side;
  logic                    sq_bad;
  logic signed [VEC_W-1:0] sq_x, sq_y, sq_z;

  e2c_sqrt #(.SIDE_W(SIDE_SQ)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (v2),
    .vx        (x2),
    .vz        (z2),
    .side_in   ({bad2, y2, x2, z2}),
    .valid_out (sq_valid),
    .root      (root),
    .side_out  (sq_side)
  );

  assign {sq_bad, sq_y, sq_x, sq_z} = sq_side;

  logic                 th_valid, ph_valid, th_bad, ph_bad;
  logic signed [AW-1:0] theta, phi;

  e2c_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (sq_valid),
    .px_in     (sq_x),
    .py_in     (sq_z),
    .side_in   (sq_bad),
    .valid_out (th_valid),
    .angle     (theta),
    .side_out  (th_bad)
  );

  e2c_cordic #(.ANGLE_BITS(ANGLE_BITS), .SIDE_W(1)) u_phi (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (sq_valid),
    .px_in     (VEC_W'(root)),
    .py_in     (sq_y),
    .side_in   (sq_bad),
    .valid_out (ph_valid),
    .angle     (phi),
    .side_out  (ph_bad)
  );

  // stage 3: clamped turn fractions
  logic signed [AW:0] u_raw, v_raw;
  logic [UW-1:0]      u_c, v_c, u3, v3;
  logic               v3_valid, bad3;

  assign u_raw = HALF + (AW+1)'(theta);
  assign v_raw = HALF - ((AW+1)'(phi) <<< 1);
  assign u_c   = (u_raw < 0) ? '0 : (u_raw > FULL) ? UW'(FULL) : UW'(u_raw);
  assign v_c   = (v_raw < 0) ? '0 : (v_raw > FULL) ? UW'(FULL) : UW'(v_raw);

  // stage 4: scaled products
  logic [PW-1:0] prod_x, prod_y;
  logic          v4, bad4;

  // stage 5: held coordinates
  logic [16:0] cx, cy;
  logic [15:0] sx_c, sy_c, sx5, sy5;
  logic        v5, bad5;

  assign cx   = 17'(prod_x >> ANGLE_BITS);
  assign cy   = 17'(prod_y >> ANGLE_BITS);
  assign sx_c = (source_width == '0) ? '0 :
                (cx > {1'b0, source_width} - 17'd1) ? source_width - 16'd1 : cx[15:0];
  assign sy_c = (source_height == '0) ? '0 :
                (cy > {1'b0, source_height} - 17'd1) ? source_height - 16'd1 : cy[15:0];

  // stage 6: row offset
  logic [31:0] row6;
  logic [15:0] sx6, sy6;
  logic        v6, bad6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3_valid  <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v3_valid  <= th_valid;
      v4        <= v3_valid;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u3     <= u_c;
      v3     <= v_c;
      bad3   <= th_bad;
      prod_x <= u3 * source_width;
      prod_y <= v3 * source_height;
      bad4   <= bad3;
      sx5    <= sx_c;
      sy5    <= sy_c;
      bad5   <= bad4;
      row6   <= sy5 * source_width;
      sx6    <= sx5;
      sy6    <= sy5;
      bad6   <= bad5;
      if (bad6) begin
        out_data <= '{sample_x: '0, sample_y: '0, source_index: '0, bad_request: 1'b1};
      end else begin
        out_data <= '{sample_x: sx6, sample_y: sy6,
                      source_index: row6 + 32'(sx6), bad_request: 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_cordic_aligned: assert property (@(posedge clk) disable iff (rst)
    (th_valid == ph_valid) && (!th_valid || th_bad == ph_bad))
    else $error("angle pipelines out of step");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_request |->
      out_data.sample_x == '0 && out_data.sample_y == '0 && out_data.source_index == '0)
    else $error("rejected word carries an address");

  a_x_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad_request && source_width != '0 |->
      out_data.sample_x < source_width)
    else $error("source column beyond width");

  a_index_sum: assert property (@(posedge clk) disable iff (rst)
    adv && v6 && !bad6 |=> out_data.source_index == $past(row6) + 32'($past(sx6)))
    else $error("index not row offset plus column");
`endif

endmodule
`default_nettype wire
